### rtl/core/oef_pkg.sv
package oef_pkg;

    // Channel count is tied to the per-channel ports of the top level
    localparam int CHANNELS         = 4;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_CHAN   = 2'd2;

    localparam logic [31:0] MIN_CUTOFF_RST = 32'd65536;

    // 2*pi in Q3.29
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // Divisor width: r + 2^24 with r below 2^35
    localparam int DEN_W = 36;

endpackage

### rtl/core/one_euro_filter_multichannel.sv
// Four-channel One Euro filter on signed Q16.16 samples with a Q8.24 time step. A frame
// is taken when the block is idle; channels are then worked one after another through
// a single 32x32 multiplier and a single bit-serial divider. An active channel with a
// nonzero time step costs three divisions of NUM_W bits (NUM_W = max(57, SAMPLE_WIDTH+25),
// one bit per cycle) plus the sequencing and multiply states. Invalid, inactive or zero
// time step channels go through S_CH and S_NEXT only. The divider sets the rate. Results
// leave through an output register, so the next frame may be accepted while one is
// waiting.
module one_euro_filter_multichannel #(
    parameter int SAMPLE_WIDTH = oef_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_3,
    input  logic [oef_pkg::CHANNELS-1:0]  i_invalid_mask,
    input  logic [31:0]                   i_time_step,
    // result requests
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_0,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_1,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_2,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_3,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [oef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CH    = oef_pkg::CHANNELS;
    localparam int CH_W  = $clog2(CH);
    localparam int DEN_W = oef_pkg::DEN_W;
    localparam int NUM_W = (SW + 25 > 57) ? SW + 25 : 57;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CH   = 4'd1;
    localparam logic [3:0] S_DDIV = 4'd2;
    localparam logic [3:0] S_AP   = 4'd3;
    localparam logic [3:0] S_AP2  = 4'd4;
    localparam logic [3:0] S_AR   = 4'd5;
    localparam logic [3:0] S_ADIV = 4'd6;
    localparam logic [3:0] S_MH   = 4'd7;
    localparam logic [3:0] S_ML   = 4'd8;
    localparam logic [3:0] S_MS   = 4'd9;
    localparam logic [3:0] S_C1   = 4'd10;
    localparam logic [3:0] S_C2   = 4'd11;
    localparam logic [3:0] S_C3   = 4'd12;
    localparam logic [3:0] S_NEXT = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]          r_state;
    logic [CH_W-1:0]     r_ch;
    logic [SW-1:0]       r_x   [CH];
    logic [SW-1:0]       r_pv  [CH];
    logic [SW-1:0]       r_pd  [CH];
    logic [SW-1:0]       r_res [CH];
    logic [SW-1:0]       r_y   [CH];
    logic [CH-1:0]       r_mask;
    logic [31:0]         r_dt;
    logic                r_ovalid;
    logic [31:0]         r_min;
    logic [31:0]         r_beta;
    logic                r_two;
    logic signed [SW:0]  r_diff;
    logic                r_neg;
    logic [SW-1:0]       r_dx;
    logic [SW-1:0]       r_dhat;
    logic [31:0]         r_fc;
    logic                r_pass;
    logic [31:0]         r_alpha;
    logic [63:0]         r_m;
    logic [65:0]         r_acc;

    // shared units
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;

    oef_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    oef_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // current channel operands
    logic [SW-1:0]      cur_x, cur_pv, cur_pd;
    logic signed [SW:0] diff_c;
    logic [SW:0]        diff_mag;
    logic               skip_ch;
    logic [NUM_W-1:0]   lim, qs;
    logic [SW-1:0]      qs_t;
    logic [32:0]        alpha_c;
    logic signed [SW:0] mf_d;
    logic [SW:0]        mf_mag;
    logic [65:0]        mf_t, mf_base, mf_res;
    logic [SW-1:0]      res_t;
    logic [SW-1:0]      res_mag;
    logic [31:0]        p_sat;
    logic [65:0]        cut_sum;
    logic [31:0]        cut_sat;

    assign cur_x  = r_x[r_ch];
    assign cur_pv = r_pv[r_ch];
    assign cur_pd = r_pd[r_ch];

    assign diff_c   = $signed({cur_x[SW-1], cur_x}) - $signed({cur_pv[SW-1], cur_pv});
    assign diff_mag = diff_c[SW] ? (SW+1)'(-diff_c) : (SW+1)'(diff_c);
    assign skip_ch  = r_mask[r_ch] || (r_two && (r_ch >= CH_W'(2)));

    // derivative saturation limit
    assign lim  = r_neg ? (NUM_W'(1) << (SW - 1)) : ((NUM_W'(1) << (SW - 1)) - NUM_W'(1));
    assign qs   = (div_quo > lim) ? lim : div_quo;
    assign qs_t = qs[SW-1:0];

    // alpha = 2^32 - floor(2^56 / (r + 2^24))
    assign alpha_c = 33'h1_0000_0000 - div_quo[32:0];

    // operand of the fractional product
    assign mf_d   = r_pass ? r_diff
                           : ($signed({r_dx[SW-1], r_dx}) - $signed({cur_pd[SW-1], cur_pd}));
    assign mf_mag = mf_d[SW] ? (SW+1)'(-mf_d) : (SW+1)'(mf_d);

    // base + signed product
    assign mf_t    = r_acc + 66'(prod[63:32]);
    assign mf_base = r_pass ? 66'($signed(cur_pv)) : 66'($signed(cur_pd));
    assign mf_res  = r_neg ? (mf_base - mf_t) : (mf_base + mf_t);
    assign res_t   = mf_res[SW-1:0];
    assign res_mag = res_t[SW-1] ? SW'(-res_t) : res_t;

    assign p_sat   = (|prod[63:48]) ? 32'hFFFF_FFFF : prod[47:16];
    assign cut_sum = r_acc + 66'(prod[63:16]) + 66'(r_min);
    assign cut_sat = (|cut_sum[65:32]) ? 32'hFFFF_FFFF : cut_sum[31:0];

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_AP:  begin mul_a = r_fc;         mul_b = r_dt;                end
            S_AP2: begin mul_a = p_sat;        mul_b = oef_pkg::TWO_PI_Q29; end
            S_MH:  begin mul_a = r_m[63:32];   mul_b = r_alpha;             end
            S_ML:  begin mul_a = r_m[31:0];    mul_b = r_alpha;             end
            S_C1:  begin mul_a = r_m[63:32];   mul_b = r_beta;              end
            S_C2:  begin mul_a = r_m[31:0];    mul_b = r_beta;              end
            default: begin mul_a = '0;         mul_b = '0;                  end
        endcase
    end

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_CH: begin
                div_start = !skip_ch && (r_dt != 32'd0);
                div_num   = NUM_W'(diff_mag) << 24;
                div_den   = DEN_W'(r_dt);
            end
            S_AR: begin
                div_start = 1'b1;
                div_num   = NUM_W'(1) << 56;
                div_den   = DEN_W'(prod[63:29]) + (DEN_W'(1) << 24);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= oef_pkg::MIN_CUTOFF_RST;
            r_beta <= '0;
            r_two  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                oef_pkg::CFG_MIN_CUTOFF: r_min  <= i_cfg_data;
                oef_pkg::CFG_SPEED_COEF: r_beta <= i_cfg_data;
                oef_pkg::CFG_TWO_CHAN:   r_two  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
            r_pass   <= 1'b0;
            for (int i = 0; i < CH; i++) begin
                r_pv[i] <= '0;
                r_pd[i] <= '0;
            end
        end else begin
            // the done state handles the output register itself
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x[0]  <= i_sample_0;
                        r_x[1]  <= i_sample_1;
                        r_x[2]  <= i_sample_2;
                        r_x[3]  <= i_sample_3;
                        r_mask  <= i_invalid_mask;
                        r_dt    <= i_time_step;
                        r_ch    <= '0;
                        r_state <= S_CH;
                    end
                end
                S_CH: begin
                    if (skip_ch) begin
                        r_res[r_ch] <= '0;
                        r_state     <= S_NEXT;
                    end else if (r_dt == 32'd0) begin
                        r_pv[r_ch]  <= cur_x;
                        r_pd[r_ch]  <= '0;
                        r_res[r_ch] <= cur_x;
                        r_state     <= S_NEXT;
                    end else begin
                        r_diff  <= diff_c;
                        r_neg   <= diff_c[SW];
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    if (div_done) begin
                        r_dx    <= r_neg ? SW'(-qs_t) : qs_t;
                        r_fc    <= r_min;
                        r_pass  <= 1'b0;
                        r_state <= S_AP;
                    end
                end
                S_AP:  r_state <= S_AP2;
                S_AP2: r_state <= S_AR;
                S_AR:  r_state <= S_ADIV;
                S_ADIV: begin
                    if (div_done) begin
                        r_alpha <= alpha_c[31:0];
                        r_m     <= 64'(mf_mag);
                        r_neg   <= mf_d[SW];
                        r_state <= S_MH;
                    end
                end
                S_MH: r_state <= S_ML;
                S_ML: begin
                    r_acc   <= 66'(prod);
                    r_state <= S_MS;
                end
                S_MS: begin
                    if (!r_pass) begin
                        r_dhat  <= res_t;
                        r_m     <= 64'(res_mag);
                        r_state <= S_C1;
                    end else begin
                        r_pv[r_ch]  <= res_t;
                        r_pd[r_ch]  <= r_dhat;
                        r_res[r_ch] <= res_t;
                        r_state     <= S_NEXT;
                    end
                end
                S_C1: r_state <= S_C2;
                S_C2: begin
                    r_acc   <= 66'(prod) << 16;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_fc    <= cut_sat;
                    r_pass  <= 1'b1;
                    r_state <= S_AP;
                end
                S_NEXT: begin
                    if (r_ch == CH_W'(CH - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_CH;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        for (int i = 0; i < CH; i++) begin
                            r_y[i] <= r_res[i];
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_filtered_0 = r_y[0];
    assign o_filtered_1 = r_y[1];
    assign o_filtered_2 = r_y[2];
    assign o_filtered_3 = r_y[3];

endmodule

### rtl/core/oef_mul.sv
// 32x32 unsigned multiplier with registered product
module oef_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/oef_div.sv
// Restoring divider, one quotient bit per cycle
module oef_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] rem_sh;
    logic           ge;

    // shift in next dividend bit and trial subtract
    assign rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
